// ----- rtl/cpc_pkg.sv -----
// Shared types and constants of the Coulomb potential unit.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package cpc_pkg;

	localparam int MAX_CHARGES = 1024;
	localparam int IDX_W       = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
	localparam int CNT_W       = $clog2(MAX_CHARGES + 1);

	localparam int COORD_W  = 32;
	localparam int CHARGE_W = 24;
	localparam int POT_W    = 48;
	localparam int ENTRY_W  = 3 * COORD_W + CHARGE_W;
	localparam int IN_W     = 120;
	localparam int OUT_W    = 56;

	// Iteration counts of the squaring multiplier and of the shared square root and divider units.
	localparam int SQ_STEPS   = 4;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 48;
	localparam int STEP_W     = 6;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_DIFF,
		S_SQ,
		S_CHK,
		S_SQRT,
		S_DIVI,
		S_DIV,
		S_ACC,
		S_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       query;
		logic       clear;
		logic       rd;
		logic       diff;
		logic       sq;
		logic [1:0] axis;
		logic       chk;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       acc;
		logic       next;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic skip;
		logic zero;
		logic last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/cpc_ctrl.sv -----
// Controller state machine of the Coulomb potential unit.
// Sequences loads, clears and the per-charge walk of a query.
// Depends on cpc_pkg.
module cpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic [1:0]    s_tuser,
	output logic          s_tready,
	input  cpc_pkg::sts_t sts,
	output cpc_pkg::cmd_t cmd
);
	import cpc_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] cnt_q;
	logic              accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// State register and the step counter, which restarts on every state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && s_tuser == ACT_QUERY)
					state_d = sts.empty ? S_DONE : S_RD;
			end
			S_RD:   state_d = S_DIFF;
			S_DIFF: state_d = S_SQ;
			S_SQ: begin
				if (cnt_q == STEP_W'(SQ_STEPS - 1))
					state_d = S_CHK;
			end
			S_CHK:  state_d = (sts.skip || sts.zero) ? S_NEXT : S_SQRT;
			S_SQRT: begin
				if (cnt_q == STEP_W'(SQRT_STEPS - 1))
					state_d = S_DIVI;
			end
			S_DIVI: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == STEP_W'(DIV_STEPS - 1))
					state_d = S_ACC;
			end
			S_ACC:  state_d = S_NEXT;
			S_NEXT: state_d = sts.last ? S_DONE : S_RD;
			S_DONE: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load  = accept && (s_tuser == ACT_LOAD);
				cmd.query = accept && (s_tuser == ACT_QUERY);
				cmd.clear = accept && (s_tuser == ACT_CLEAR);
			end
			S_RD:   cmd.rd = 1'b1;
			S_DIFF: cmd.diff = 1'b1;
			S_SQ: begin
				cmd.sq   = 1'b1;
				cmd.axis = cnt_q[1:0];
			end
			S_CHK:  cmd.chk = 1'b1;
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_DIVI: cmd.div_init = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_ACC:  cmd.acc = 1'b1;
			S_NEXT: cmd.next = 1'b1;
			S_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/cpc_datapath.sv -----
// Datapath of the Coulomb potential unit: charge store, squared distance,
// bit-serial square root and divider, saturating sum and output register.
// Depends on cpc_pkg.
module cpc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cpc_pkg::cmd_t              cmd,
	output cpc_pkg::sts_t              sts,
	input  logic [cpc_pkg::IN_W-1:0]   s_tdata,
	input  logic                       cfg_we,
	input  logic [31:0]                cfg_wdata,
	output logic [31:0]                cutoff,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cpc_pkg::OUT_W-1:0]  m_tdata
);
	import cpc_pkg::*;

	logic [ENTRY_W-1:0]  charge_mem [MAX_CHARGES];
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic                overflow_q;
	logic [31:0]         cutoff_q;
	logic [63:0]         cut2_q;
	logic [COORD_W-1:0]  qx_q, qy_q, qz_q;
	logic [31:0]         mx_q, my_q, mz_q;
	logic [CHARGE_W-1:0] chg_q;
	logic [63:0]         prod_q;
	logic [65:0]         norm_q;
	logic [63:0]         n_q;
	logic [33:0]         rem_q;
	logic [31:0]         root_q;
	logic [31:0]         rmd_q;
	logic [47:0]         dvd_q;
	logic [POT_W-1:0]    sum_q;
	logic                sat_q, coinc_q;
	logic [POT_W-1:0]    out_pot_q;
	logic                out_sat_q, out_coinc_q, out_ovf_q, out_valid_q;

	logic                full;
	logic [31:0]         mag_sel;
	logic [35:0]         rem_sh, trial;
	logic [32:0]         div_t;
	logic [CHARGE_W-1:0] chg_mag;
	logic [POT_W:0]      term, sum_ext;

	// Absolute difference of two signed coordinates; always below 2^32.
	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? (~d + 33'd1) : d;
		return m[31:0];
	endfunction

	assign full   = (count_q == CNT_W'(MAX_CHARGES));
	assign cutoff = cutoff_q;

	// Charge store, written in load order and read with a registered port.
	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			charge_mem[count_q[IDX_W-1:0]] <= s_tdata[ENTRY_W-1:0];
		if (cmd.rd)
			rd_data_q <= charge_mem[idx_q[IDX_W-1:0]];
	end

	// Fill count, overflow flag, walk index and cutoff register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			idx_q      <= '0;
			cutoff_q   <= '1;
		end else begin
			if (cfg_we)
				cutoff_q <= cfg_wdata;
			if (cmd.clear) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.load) begin
				if (full)
					overflow_q <= 1'b1;
				else
					count_q <= count_q + 1'b1;
			end
			if (cmd.query)
				idx_q <= '0;
			else if (cmd.next)
				idx_q <= idx_q + 1'b1;
		end
	end

	// Query latch and distance arithmetic; one shared multiplier walks the axes.
	always_comb begin
		case (cmd.axis)
			2'd0:    mag_sel = mx_q;
			2'd1:    mag_sel = my_q;
			2'd2:    mag_sel = mz_q;
			default: mag_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			qx_q   <= s_tdata[31:0];
			qy_q   <= s_tdata[63:32];
			qz_q   <= s_tdata[95:64];
			cut2_q <= cutoff_q * cutoff_q;
		end
		if (cmd.diff) begin
			mx_q  <= abs_diff(rd_data_q[31:0], qx_q);
			my_q  <= abs_diff(rd_data_q[63:32], qy_q);
			mz_q  <= abs_diff(rd_data_q[95:64], qz_q);
			chg_q <= rd_data_q[ENTRY_W-1:96];
		end
		if (cmd.sq) begin
			prod_q <= mag_sel * mag_sel;
			norm_q <= (cmd.axis == 2'd0) ? '0 : norm_q + {2'b00, prod_q};
		end
	end

	assign sts.skip = (norm_q >= {2'b00, cut2_q});
	assign sts.zero = (norm_q == '0);

	// Restoring square root, two radicand bits per step.
	assign rem_sh = {rem_q, n_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};

	// Restoring division of |q| * 2^24 by the root, one quotient bit per step.
	assign chg_mag = chg_q[CHARGE_W-1] ? (~chg_q + 1'b1) : chg_q;
	assign div_t   = {rmd_q, dvd_q[47]};

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			n_q    <= norm_q[63:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			n_q <= {n_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			rmd_q <= '0;
			dvd_q <= {chg_mag, 24'd0};
		end else if (cmd.div_step) begin
			if (div_t >= {1'b0, root_q}) begin
				rmd_q <= 32'(div_t - {1'b0, root_q});
				dvd_q <= {dvd_q[46:0], 1'b1};
			end else begin
				rmd_q <= div_t[31:0];
				dvd_q <= {dvd_q[46:0], 1'b0};
			end
		end
	end

	// Signed term and saturating sum.
	assign term    = chg_q[CHARGE_W-1] ? (~{1'b0, dvd_q} + 1'b1) : {1'b0, dvd_q};
	assign sum_ext = {sum_q[POT_W-1], sum_q} + term;

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			sum_q   <= '0;
			sat_q   <= 1'b0;
			coinc_q <= 1'b0;
		end else begin
			if (cmd.chk && !sts.skip && sts.zero)
				coinc_q <= 1'b1;
			if (cmd.acc) begin
				if (sum_ext[POT_W] != sum_ext[POT_W-1]) begin
					sum_q <= sum_ext[POT_W] ? {1'b1, {(POT_W-1){1'b0}}}
					                        : {1'b0, {(POT_W-1){1'b1}}};
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[POT_W-1:0];
				end
			end
		end
	end

	assign sts.empty    = (count_q == '0);
	assign sts.last     = ((idx_q + 1'b1) == count_q);
	assign sts.out_free = !out_valid_q || m_tready;

	// Output register; it holds a finished result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pot_q   <= sum_q;
			out_sat_q   <= sat_q;
			out_coinc_q <= coinc_q;
			out_ovf_q   <= overflow_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_ovf_q, out_coinc_q, out_sat_q, out_pot_q};

endmodule

// ----- rtl/coulomb_potential_with_cutoff_unit.sv -----
// Top level of the Coulomb potential unit with cutoff radius.
// Instantiates cpc_ctrl and cpc_datapath; depends on cpc_pkg.
//
// Usage:
// The input stream carries one item per transfer: tuser selects load
// charge, query point or clear store. Loads store (x, y, z, q) in load
// order; a load into a full store is dropped and flagged. A clear empties
// the store. Only a query makes a result on the output stream: the Q24.24
// potential and three flags. The APB port writes and reads cutoff_radius.
// Timing:
// A load or clear leaves the input ready for the next item. A query walks
// every stored charge through one multiplier, a bit-serial square root
// (32 steps) and a bit-serial divider (48 steps); a charge outside the
// cutoff or at zero distance skips the square root and the divider. The
// result becomes valid at the same edge at which the input is ready again,
// and the next item is taken while that result may still wait in the
// output register. If the receiver stalls, a later query holds in its
// final cycle until the output register is free. Reset empties the store,
// clears the overflow and output valid flags and sets the cutoff to its
// largest value.
module coulomb_potential_with_cutoff_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64], charge_value [119:96]
	input  logic [119:0] s_tdata,
	// action [1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// potential [47:0], sum_saturated [48], coincident_skipped [49],
	// store_overflowed [50], zero fill [55:51]
	output logic [55:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import cpc_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic        cfg_we;
	logic [31:0] cutoff;

	// Register access: cutoff_radius at byte address 0.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : cutoff;

	cpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata),
		.cutoff    (cutoff),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- rtl/cpc_checker.sv -----
// Port-level checks of the Coulomb potential unit, bound to its top level.
// Depends on cpc_pkg.
module cpc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [55:0]  m_tdata,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic [2:0]   paddr,
	input logic [31:0]  pwdata,
	input logic [31:0]  prdata,
	input logic         pready
);
	import cpc_pkg::*;

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A query keeps the unit busy for at least the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_QUERY |=> !s_tready)
		else $error("item taken right after a query");

	// The fill bits of a result are zero.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:51] == 5'd0)
		else $error("result fill bits set");

	// A written cutoff reads back on the next cycle.
	a_rdback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2]
		|=> paddr[2] || prdata == $past(pwdata))
		else $error("cutoff read back wrong");

endmodule

bind coulomb_potential_with_cutoff_unit cpc_checker u_cpc_checker (.*);
